// ===== src/sais_pkg.sv =====
// ----------------------------------------------------------------------------
// sais_pkg
// Shared constants for the shift array insert/delete/search core.
// ----------------------------------------------------------------------------
package sais_pkg;

   localparam int DEPTH = 16;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int LEN_W = 5;
   localparam int ACT_W = 2;
   localparam int STAT_W = 2;
   localparam int FIDX_W = 4;
   localparam int DATA_W = 32;

   localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(DEPTH);

   localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
   localparam logic [ACT_W-1:0] ACT_DELETE = 2'd1;
   localparam logic [ACT_W-1:0] ACT_SEARCH = 2'd2;
   localparam logic [ACT_W-1:0] ACT_DUMP = 2'd3;

   localparam logic [STAT_W-1:0] ST_OK = 2'd0;
   localparam logic [STAT_W-1:0] ST_BAD_POS = 2'd1;
   localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;

endpackage

// ===== src/sais_if.sv =====
// ----------------------------------------------------------------------------
// sais request / response channels
// Valid/ready channels carrying one request or one response item.
// ----------------------------------------------------------------------------
interface sais_req_if;
   logic                               valid;
   logic                               ready;
   logic [sais_pkg::ACT_W-1:0]         action;
   logic signed [sais_pkg::DATA_W-1:0] value_in;
   logic [sais_pkg::LEN_W-1:0]         position;

   modport source (output valid, output action, output value_in, output position,
                   input ready);
   modport sink (input valid, input action, input value_in, input position,
                 output ready);
endinterface

interface sais_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [sais_pkg::STAT_W-1:0]        status;
   logic [sais_pkg::FIDX_W-1:0]        found_index;
   logic signed [sais_pkg::DATA_W-1:0] value_out;
   logic                               last;

   modport source (output valid, output status, output found_index, output value_out,
                   output last, input ready);
   modport sink (input valid, input status, input found_index, input value_out,
                 input last, output ready);
endinterface

// ===== src/shift_array_insert_delete_search_core.sv =====
// ----------------------------------------------------------------------------
// shift_array_insert_delete_search_core
// Entry array with insert, delete, linear search and dump, run by a small
// sequencer around a one-read, one-write entry memory.
// ----------------------------------------------------------------------------
// Each request runs to completion before the next is taken. Every entry the
// sequencer touches is first read from the entry memory and then compared or
// moved, since the memory has one read and one write port. With L the length
// in use, an insert at p moves entries p to L-2 up one and writes the value at
// p, a delete moves p+1 to L-1 down one, a search stops at the first match and
// a dump waits while the response side stalls. Out-of-range positions touch no
// entry. The entries read as zero after reset without a clearing pass.
module shift_array_insert_delete_search_core (
   input  logic                               clock,
   input  logic                               reset,
   sais_req_if.sink                           req,
   sais_rsp_if.source                         rsp,
   input  logic                               csr_wr_en,
   input  logic [sais_pkg::LEN_W-1:0]         csr_wr_data
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_RD   = 3'd1;
   localparam logic [2:0] S_EX   = 3'd2;
   localparam logic [2:0] S_WFIN = 3'd3;
   localparam logic [2:0] S_RSP  = 3'd4;

   localparam int LW = sais_pkg::LEN_W;
   localparam int IW = sais_pkg::IDX_W;
   localparam int DW = sais_pkg::DATA_W;

   logic [2:0]                     state_ff, state_in;
   logic [LW-1:0]                  len_ff;
   logic [sais_pkg::ACT_W-1:0]     act_ff, act_in;
   logic signed [DW-1:0]           val_ff, val_in;
   logic [LW-1:0]                  pos_ff, pos_in;
   logic [LW-1:0]                  n_ff, n_in;
   logic [LW-1:0]                  k_ff, k_in;
   logic                           first_ff, first_in;

   logic [sais_pkg::STAT_W-1:0]    res_stat_ff, res_stat_in;
   logic [sais_pkg::FIDX_W-1:0]    res_idx_ff, res_idx_in;
   logic signed [DW-1:0]           res_val_ff, res_val_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [sais_pkg::STAT_W-1:0]    rsp_stat_ff, rsp_stat_in;
   logic [sais_pkg::FIDX_W-1:0]    rsp_idx_ff, rsp_idx_in;
   logic signed [DW-1:0]           rsp_val_ff, rsp_val_in;
   logic                           rsp_last_ff, rsp_last_in;

   logic signed [DW-1:0]           mem [sais_pkg::DEPTH];
   logic [sais_pkg::DEPTH-1:0]     vld_ff;
   logic signed [DW-1:0]           rd_data_ff;
   logic                           rd_vld_ff;
   logic [IW-1:0]                  rd_addr;
   logic                           wr_en;
   logic [IW-1:0]                  wr_addr;
   logic signed [DW-1:0]           wr_data;
   logic signed [DW-1:0]           rdata;

   logic [LW-1:0]                  eff_len;
   logic                           accept;
   logic                           slot_free;
   logic [LW-1:0]                  k_inc;
   logic [LW-1:0]                  k_dec;

   assign eff_len = (len_ff == '0) ? LW'(1) :
                    (len_ff > sais_pkg::LEN_MAX) ? sais_pkg::LEN_MAX : len_ff;
   assign req.ready = (state_ff == S_IDLE);
   assign accept = req.valid && req.ready;
   assign slot_free = !rsp_valid_ff || rsp.ready;
   assign rdata = rd_vld_ff ? rd_data_ff : '0;
   assign k_inc = k_ff + LW'(1);
   assign k_dec = k_ff - LW'(1);

   assign rsp.valid = rsp_valid_ff;
   assign rsp.status = rsp_stat_ff;
   assign rsp.found_index = rsp_idx_ff;
   assign rsp.value_out = rsp_val_ff;
   assign rsp.last = rsp_last_ff;

   // read address: insert reads the entry below the one being written
   always_comb begin
      if (act_ff == sais_pkg::ACT_INSERT) begin
         rd_addr = k_dec[IW-1:0];
      end else begin
         rd_addr = k_ff[IW-1:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      act_in = act_ff;
      val_in = val_ff;
      pos_in = pos_ff;
      n_in = n_ff;
      k_in = k_ff;
      first_in = first_ff;
      res_stat_in = res_stat_ff;
      res_idx_in = res_idx_ff;
      res_val_in = res_val_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_stat_in = rsp_stat_ff;
      rsp_idx_in = rsp_idx_ff;
      rsp_val_in = rsp_val_ff;
      rsp_last_in = rsp_last_ff;
      wr_en = 1'b0;
      wr_addr = k_ff[IW-1:0];
      wr_data = rdata;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               act_in = req.action;
               val_in = req.value_in;
               pos_in = req.position;
               n_in = eff_len;
               first_in = 1'b1;
               res_stat_in = sais_pkg::ST_OK;
               res_idx_in = '0;
               res_val_in = '0;
               k_in = '0;
               unique case (req.action)
                  sais_pkg::ACT_INSERT: begin
                     k_in = eff_len - LW'(1);
                     if (req.position > eff_len) begin
                        res_stat_in = sais_pkg::ST_BAD_POS;
                        state_in = S_RSP;
                     end else if (req.position == eff_len) begin
                        state_in = S_RSP;
                     end else if (eff_len - LW'(1) > req.position) begin
                        state_in = S_RD;
                     end else begin
                        state_in = S_WFIN;
                     end
                  end
                  sais_pkg::ACT_DELETE: begin
                     k_in = req.position;
                     if (req.position >= eff_len) begin
                        res_stat_in = sais_pkg::ST_BAD_POS;
                        state_in = S_RSP;
                     end else begin
                        state_in = S_RD;
                     end
                  end
                  default: begin
                     state_in = S_RD;
                  end
               endcase
            end
         end
         S_RD: begin
            if (act_ff != sais_pkg::ACT_DUMP || slot_free) begin
               state_in = S_EX;
            end
         end
         S_EX: begin
            unique case (act_ff)
               sais_pkg::ACT_INSERT: begin
                  wr_en = 1'b1;
                  wr_addr = k_ff[IW-1:0];
                  k_in = k_dec;
                  state_in = (k_dec > pos_ff) ? S_RD : S_WFIN;
               end
               sais_pkg::ACT_DELETE: begin
                  if (first_ff) begin
                     res_val_in = rdata;
                     first_in = 1'b0;
                  end else begin
                     wr_en = 1'b1;
                     wr_addr = k_dec[IW-1:0];
                  end
                  k_in = k_inc;
                  state_in = (k_inc < n_ff) ? S_RD : S_RSP;
               end
               sais_pkg::ACT_SEARCH: begin
                  if (rdata == val_ff) begin
                     res_idx_in = sais_pkg::FIDX_W'(k_ff);
                     state_in = S_RSP;
                  end else if (k_inc < n_ff) begin
                     k_in = k_inc;
                     state_in = S_RD;
                  end else begin
                     res_stat_in = sais_pkg::ST_NOT_FOUND;
                     state_in = S_RSP;
                  end
               end
               default: begin
                  rsp_valid_in = 1'b1;
                  rsp_stat_in = sais_pkg::ST_OK;
                  rsp_idx_in = '0;
                  rsp_val_in = rdata;
                  rsp_last_in = (k_inc == n_ff);
                  k_in = k_inc;
                  state_in = (k_inc == n_ff) ? S_IDLE : S_RD;
               end
            endcase
         end
         S_WFIN: begin
            wr_en = 1'b1;
            wr_addr = pos_ff[IW-1:0];
            wr_data = val_ff;
            state_in = S_RSP;
         end
         S_RSP: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_stat_in = res_stat_ff;
               rsp_idx_in = res_idx_ff;
               rsp_val_in = res_val_ff;
               rsp_last_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         len_ff <= sais_pkg::LEN_MAX;
         rsp_valid_ff <= 1'b0;
         vld_ff <= '0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            len_ff <= csr_wr_data;
         end
         if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      act_ff <= act_in;
      val_ff <= val_in;
      pos_ff <= pos_in;
      n_ff <= n_in;
      k_ff <= k_in;
      first_ff <= first_in;
      res_stat_ff <= res_stat_in;
      res_idx_ff <= res_idx_in;
      res_val_ff <= res_val_in;
      rsp_stat_ff <= rsp_stat_in;
      rsp_idx_ff <= rsp_idx_in;
      rsp_val_ff <= rsp_val_in;
      rsp_last_ff <= rsp_last_in;
   end

   // entry memory: one write, one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
      rd_vld_ff <= vld_ff[rd_addr] && !reset;
   end

   // dump loads the response register only when it is empty
   a_dump_slot_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EX && act_ff == sais_pkg::ACT_DUMP) |-> !rsp_valid_ff)
      else $error("dump entry would overwrite a pending response");

   // shifting never writes beyond the length in use
   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> ({1'b0, wr_addr} < n_ff))
      else $error("entry write outside the length in use");

   // an accepted request starts the sequencer on the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != S_IDLE))
      else $error("request accepted without starting the sequencer");

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the shift array core. A directed table covers the
// reset contents, the position bounds and the value extremes. Random
// requests follow over several length settings. Every response is checked,
// typed table rows against their expected fields and the rest against an
// in-bench model of the entry array. Both channels idle at random, and once
// the response side holds off long enough to back up the request channel.
// ----------------------------------------------------------------------------
module tb;

   localparam int DEPTH  = sais_pkg::DEPTH;
   localparam int LEN_W  = sais_pkg::LEN_W;
   localparam int ACT_W  = sais_pkg::ACT_W;
   localparam int STAT_W = sais_pkg::STAT_W;
   localparam int FIDX_W = sais_pkg::FIDX_W;
   localparam int DATA_W = sais_pkg::DATA_W;

   localparam int N_PHASES    = 8;
   localparam int PHASE_ITEMS = 31;
   localparam int IDLE_LIMIT  = 2000;
   localparam int DRAIN_CYC   = 40;
   localparam int HOLD_CYC    = 300;

   typedef struct packed {
      logic [STAT_W-1:0]        status;
      logic [FIDX_W-1:0]        found_index;
      logic signed [DATA_W-1:0] value_out;
      logic                     last;
   } rsp_type;

   typedef struct {
      logic [ACT_W-1:0]  act;
      logic [DATA_W-1:0] val;
      logic [LEN_W-1:0]  pos;
      bit                typed;
      logic [STAT_W-1:0] st;
      logic [FIDX_W-1:0] fidx;
      logic [DATA_W-1:0] vout;
   } step_type;

   localparam int N_DIR = 24;

   // typed rows assume a start from the reset state (all entries zero, length 16) and the rows before them
   step_type directed_steps [N_DIR] = '{
      '{sais_pkg::ACT_SEARCH, 32'h0000_0000, 5'd0,  1'b1, sais_pkg::ST_OK, 4'd0, 32'h0},
      '{sais_pkg::ACT_SEARCH, 32'h8000_0000, 5'd0,  1'b1, sais_pkg::ST_NOT_FOUND, 4'd0, 32'h0},
      '{sais_pkg::ACT_DUMP,   32'h0000_0000, 5'd0,  1'b0, sais_pkg::ST_OK, 4'd0, 32'h0},
      '{sais_pkg::ACT_INSERT, 32'h7FFF_FFFF, 5'd0,  1'b1, sais_pkg::ST_OK, 4'd0, 32'h0},
      '{sais_pkg::ACT_INSERT, 32'h8000_0000, 5'd15, 1'b1, sais_pkg::ST_OK, 4'd0, 32'h0},
      '{sais_pkg::ACT_INSERT, 32'hFFFF_FFFF, 5'd16, 1'b1, sais_pkg::ST_OK, 4'd0, 32'h0},
      '{sais_pkg::ACT_INSERT, 32'h0000_0001, 5'd17, 1'b1, sais_pkg::ST_BAD_POS, 4'd0, 32'h0},
      '{sais_pkg::ACT_INSERT, 32'h0000_0002, 5'd31, 1'b1, sais_pkg::ST_BAD_POS, 4'd0, 32'h0},
      '{sais_pkg::ACT_DELETE, 32'h0000_0000, 5'd16, 1'b1, sais_pkg::ST_BAD_POS, 4'd0, 32'h0},
      '{sais_pkg::ACT_DELETE, 32'hFFFF_FFFF, 5'd31, 1'b1, sais_pkg::ST_BAD_POS, 4'd0, 32'h0},
      '{sais_pkg::ACT_SEARCH, 32'h7FFF_FFFF, 5'd0,  1'b1, sais_pkg::ST_OK, 4'd0, 32'h0},
      '{sais_pkg::ACT_SEARCH, 32'h8000_0000, 5'd0,  1'b1, sais_pkg::ST_OK, 4'd15, 32'h0},
      '{sais_pkg::ACT_SEARCH, 32'hFFFF_FFFF, 5'd0,  1'b1, sais_pkg::ST_NOT_FOUND, 4'd0, 32'h0},
      '{sais_pkg::ACT_DELETE, 32'h0000_0000, 5'd0,  1'b1, sais_pkg::ST_OK, 4'd0,
        32'h7FFF_FFFF},
      '{sais_pkg::ACT_SEARCH, 32'h8000_0000, 5'd0,  1'b0, sais_pkg::ST_OK, 4'd0, 32'h0},
      '{sais_pkg::ACT_DUMP,   32'hFFFF_FFFF, 5'd31, 1'b0, sais_pkg::ST_OK, 4'd0, 32'h0},
      '{sais_pkg::ACT_INSERT, 32'h1234_5678, 5'd3,  1'b0, sais_pkg::ST_OK, 4'd0, 32'h0},
      '{sais_pkg::ACT_INSERT, 32'h5A5A_5A5A, 5'd3,  1'b0, sais_pkg::ST_OK, 4'd0, 32'h0},
      '{sais_pkg::ACT_INSERT, 32'hA5A5_A5A5, 5'd10, 1'b0, sais_pkg::ST_OK, 4'd0, 32'h0},
      '{sais_pkg::ACT_DELETE, 32'h0000_0000, 5'd15, 1'b0, sais_pkg::ST_OK, 4'd0, 32'h0},
      '{sais_pkg::ACT_SEARCH, 32'h1234_5678, 5'd0,  1'b0, sais_pkg::ST_OK, 4'd0, 32'h0},
      '{sais_pkg::ACT_DELETE, 32'h0000_0000, 5'd3,  1'b0, sais_pkg::ST_OK, 4'd0, 32'h0},
      '{sais_pkg::ACT_DUMP,   32'h0000_0000, 5'd0,  1'b0, sais_pkg::ST_OK, 4'd0, 32'h0},
      '{sais_pkg::ACT_SEARCH, 32'h0000_0000, 5'd0,  1'b0, sais_pkg::ST_OK, 4'd0, 32'h0}
   };

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [LEN_W-1:0] csr_wr_data;

   sais_req_if req_ch ();
   sais_rsp_if rsp_ch ();

   shift_array_insert_delete_search_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   logic signed [DATA_W-1:0] entry_model [DEPTH];
   logic [LEN_W-1:0]         length_reg;
   rsp_type                  step_results [$];
   rsp_type                  expected_rsp [$];
   int                       errors;
   int                       idle_cycles;
   bit                       tx_burst;
   bit                       rx_burst;
   bit                       hold_rx;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int active_len();
      int n;
      n = int'(length_reg);
      if (n < 1) n = 1;
      if (n > DEPTH) n = DEPTH;
      return n;
   endfunction

   function automatic rsp_type mk_rsp(logic [STAT_W-1:0] st, logic [FIDX_W-1:0] fidx,
                                      logic [DATA_W-1:0] vout, logic lst);
      rsp_type r;
      r.status      = st;
      r.found_index = fidx;
      r.value_out   = vout;
      r.last        = lst;
      return r;
   endfunction

   // applies one request to the entry model, leaves its responses in step_results
   task automatic apply_request(input logic [ACT_W-1:0] act, input logic [DATA_W-1:0] val,
                                input logic [LEN_W-1:0] pos);
      int n;
      int i;
      int hit;
      logic [DATA_W-1:0] removed;
      n = active_len();
      step_results = {};
      case (act)
         sais_pkg::ACT_INSERT: begin
            if (pos > n) begin
               step_results.push_back(mk_rsp(sais_pkg::ST_BAD_POS, '0, '0, 1'b1));
            end else begin
               if (pos < n) begin
                  for (i = n - 1; i > pos; i--) entry_model[i] = entry_model[i-1];
                  entry_model[pos] = val;
               end
               step_results.push_back(mk_rsp(sais_pkg::ST_OK, '0, '0, 1'b1));
            end
         end
         sais_pkg::ACT_DELETE: begin
            if (pos >= n) begin
               step_results.push_back(mk_rsp(sais_pkg::ST_BAD_POS, '0, '0, 1'b1));
            end else begin
               removed = entry_model[pos];
               for (i = pos; i + 1 < n; i++) entry_model[i] = entry_model[i+1];
               step_results.push_back(mk_rsp(sais_pkg::ST_OK, '0, removed, 1'b1));
            end
         end
         sais_pkg::ACT_SEARCH: begin
            hit = -1;
            for (i = 0; i < n; i++) begin
               if (hit < 0 && entry_model[i] == val) hit = i;
            end
            if (hit >= 0) begin
               step_results.push_back(mk_rsp(sais_pkg::ST_OK, FIDX_W'(hit), '0, 1'b1));
            end else begin
               step_results.push_back(mk_rsp(sais_pkg::ST_NOT_FOUND, '0, '0, 1'b1));
            end
         end
         default: begin
            for (i = 0; i < n; i++) begin
               step_results.push_back(mk_rsp(sais_pkg::ST_OK, '0, entry_model[i],
                                             i + 1 == n));
            end
         end
      endcase
   endtask

   task automatic send_request(input logic [ACT_W-1:0] act, input logic [DATA_W-1:0] val,
                               input logic [LEN_W-1:0] pos, input bit typed,
                               input rsp_type typed_rsp);
      int gap;
      if ($urandom_range(0, 11) == 0) tx_burst = !tx_burst;
      gap = tx_burst ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.action   <= act;
      req_ch.value_in <= val;
      req_ch.position <= pos;
      do @(posedge clock); while (!(req_ch.valid && req_ch.ready));
      apply_request(act, val, pos);
      if (typed) expected_rsp.push_back(typed_rsp);
      else foreach (step_results[k]) expected_rsp.push_back(step_results[k]);
   endtask

   task automatic set_length(input logic [LEN_W-1:0] len);
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= len;
      @(posedge clock);
      length_reg = len;
      csr_wr_en <= 1'b0;
   endtask

   // response side: random stalls, one long hold-off on request
   initial begin
      int stall;
      bit hold_done;
      hold_done = 1'b0;
      rsp_ch.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if ($urandom_range(0, 11) == 0) rx_burst = !rx_burst;
         stall = rx_burst ? 0 : $urandom_range(0, 17);
         if (hold_rx && !hold_done) begin
            hold_done = 1'b1;
            stall     = HOLD_CYC;
         end
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_ch.valid && rsp_ch.ready));
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_rsp.size() == 0) begin
            errors++;
            $display("%0t: response with none expected: status %0d idx %0d value %h last %b",
                     $time, rsp_ch.status, rsp_ch.found_index, rsp_ch.value_out,
                     rsp_ch.last);
         end else begin
            want = expected_rsp.pop_front();
            if (rsp_ch.status !== want.status) begin
               errors++;
               $display("%0t: status expected %0d got %0d", $time, want.status,
                        rsp_ch.status);
            end
            if (rsp_ch.found_index !== want.found_index) begin
               errors++;
               $display("%0t: found_index expected %0d got %0d", $time,
                        want.found_index, rsp_ch.found_index);
            end
            if (rsp_ch.value_out !== want.value_out) begin
               errors++;
               $display("%0t: value_out expected %h got %h", $time, want.value_out,
                        rsp_ch.value_out);
            end
            if (rsp_ch.last !== want.last) begin
               errors++;
               $display("%0t: last expected %b got %b", $time, want.last, rsp_ch.last);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || csr_wr_en || (req_ch.valid && req_ch.ready) ||
          (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no progress for %0d cycles, %0d responses pending", $time,
                  IDLE_LIMIT, expected_rsp.size());
         $display("tb: done, errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      logic [LEN_W-1:0]  phase_len [N_PHASES];
      logic [ACT_W-1:0]  act;
      logic [DATA_W-1:0] val;
      logic [LEN_W-1:0]  pos;
      int                p;
      int                k;
      int                n;
      int                r;
      tx_burst    = 1'b0;
      hold_rx     = 1'b0;
      length_reg  = sais_pkg::LEN_MAX;
      foreach (entry_model[i]) entry_model[i] = '0;
      reset           <= 1'b1;
      csr_wr_en       <= 1'b0;
      csr_wr_data     <= '0;
      req_ch.valid    <= 1'b0;
      req_ch.action   <= sais_pkg::ACT_INSERT;
      req_ch.value_in <= '0;
      req_ch.position <= '0;
      phase_len = '{5'd1, 5'd0, 5'd16, 5'd31, 5'd17, 5'd4,
                    LEN_W'($urandom_range(1, 16)), LEN_W'($urandom_range(0, 31))};
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (k = 0; k < N_DIR; k++) begin
         send_request(directed_steps[k].act, directed_steps[k].val, directed_steps[k].pos,
                      directed_steps[k].typed,
                      mk_rsp(directed_steps[k].st, directed_steps[k].fidx,
                             directed_steps[k].vout, 1'b1));
      end

      for (p = 0; p < N_PHASES; p++) begin
         req_ch.valid <= 1'b0;
         set_length(phase_len[p]);
         if (p == 2) hold_rx = 1'b1;
         for (k = 0; k < PHASE_ITEMS; k++) begin
            n = active_len();
            r = $urandom_range(0, 99);
            act = (r < 35) ? sais_pkg::ACT_INSERT : (r < 60) ? sais_pkg::ACT_DELETE :
                  (r < 90) ? sais_pkg::ACT_SEARCH : sais_pkg::ACT_DUMP;
            pos = ($urandom_range(0, 9) == 0) ? LEN_W'($urandom_range(0, 31))
                                              : LEN_W'($urandom_range(0, n));
            case ($urandom_range(0, 3))
               0: val = DATA_W'($urandom_range(0, 7));
               1: val = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
               2: val = $urandom;
               default: val = entry_model[$urandom_range(0, n - 1)];
            endcase
            send_request(act, val, pos, 1'b0, '0);
         end
      end
      req_ch.valid <= 1'b0;

      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYC) @(posedge clock);
      if (errors == 0 && expected_rsp.size() == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("%0t: %0d mismatches, %0d responses missing", $time, errors,
                  expected_rsp.size());
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule
